/* rtl/lld_pkg.sv */
// lld_pkg: shared sizes, codes, the candidate type and the saturating
// arithmetic for the least-loaded dispatcher
// depends on nothing
package lld_pkg;

   localparam int MAX_SERVERS = 16;
   localparam int REQ_SLOTS   = 256;

   localparam int CSR_W    = 5;
   localparam int TAG_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int LOAD_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int ERR_W    = 2;

   localparam int SRV_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int SLOT_W      = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
   localparam int CMP_W       = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int TREE_LEVELS = $clog2(MAX_SERVERS);
   localparam int TREE_SIZE   = 1 << TREE_LEVELS;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 2);

   localparam logic FUNC_ASSIGN = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NO_SERVERS  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN_TAG = 2'd2;

   typedef struct packed {
      logic              ok;
      logic [SRV_W-1:0]  idx;
      logic [LOAD_W-1:0] load;
   } cand_type;

   // tag to table slot, wrapping at the table size
   function automatic logic [SLOT_W-1:0] slot_of(input logic [TAG_W-1:0] tag);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int v = 0; v < (1 << TAG_W); v++) begin
         if (tag == TAG_W'(v)) begin
            r = SLOT_W'(v % REQ_SLOTS);
         end
      end
      return r;
   endfunction

   function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] load,
                                                 input logic [WEIGHT_W-1:0] weight);
      logic [LOAD_W:0] s;
      s = {1'b0, load} + (LOAD_W + 1)'(weight);
      return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
   endfunction

   function automatic logic [LOAD_W-1:0] sat_sub(input logic [LOAD_W-1:0] load,
                                                 input logic [WEIGHT_W-1:0] weight);
      logic [LOAD_W-1:0] w;
      w = LOAD_W'(weight);
      return (load > w) ? (load - w) : '0;
   endfunction

endpackage

/* rtl/lld_min_tree.sv */
// lld_min_tree: iterative pairwise minimum search, one tree level per cycle,
// lowest index wins a tie
// depends on lld_pkg
module lld_min_tree (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lld_pkg::cand_type cands [lld_pkg::TREE_SIZE],
   output logic             done,
   output lld_pkg::cand_type winner
);

   lld_pkg::cand_type cand_ff [lld_pkg::TREE_SIZE];
   lld_pkg::cand_type cand_in [lld_pkg::TREE_SIZE];
   logic [lld_pkg::LVL_W-1:0] level_ff;
   logic                      busy_ff;

   function automatic lld_pkg::cand_type pick(input lld_pkg::cand_type a,
                                              input lld_pkg::cand_type b);
      return (a.ok && (!b.ok || a.load <= b.load)) ? a : b;
   endfunction

   always_comb begin
      cand_in = cand_ff;
      for (int i = 0; i < lld_pkg::TREE_SIZE / 2; i++) begin
         cand_in[i] = pick(cand_ff[2 * i], cand_ff[2 * i + 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         level_ff <= lld_pkg::LVL_W'(lld_pkg::TREE_LEVELS);
      end else if (busy_ff) begin
         if (level_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cand_ff <= cands;
      end else if (busy_ff && level_ff != '0) begin
         cand_ff <= cand_in;
      end
   end

   assign done   = busy_ff && (level_ff == '0);
   assign winner = cand_ff[0];

endmodule

/* rtl/least_loaded_dispatcher.sv */
// least_loaded_dispatcher: top level, load registers, request table and sequencer
// depends on lld_pkg and lld_min_tree
//
// One item is handled at a time. A finish item reads the request table
// synchronously after the transfer, then updates the server load and gives
// the result. An assign item looks up, then the least-loaded search runs one
// pairwise level of the load registers per cycle in a shared compare unit,
// then the winner's load is updated. While an earlier result is not taken,
// the item waits in its last state. The valid bits of the request table clear
// at reset, so no clearing pass is needed.
module least_loaded_dispatcher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [lld_pkg::CSR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [lld_pkg::TAG_W-1:0]     req_request_tag,
   input  logic [lld_pkg::WEIGHT_W-1:0]  req_work_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lld_pkg::INDEX_W-1:0]   rsp_server_index,
   output logic [lld_pkg::LOAD_W-1:0]    rsp_server_load_now,
   output logic [lld_pkg::ERR_W-1:0]     rsp_error_code
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOK   = 2'd1;
   localparam logic [1:0] ST_REDUCE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [lld_pkg::CSR_W-1:0]    active_ff;
   logic                         func_ff;
   logic [lld_pkg::SLOT_W-1:0]   slot_ff;
   logic [lld_pkg::WEIGHT_W-1:0] weight_ff;

   logic [lld_pkg::LOAD_W-1:0]   load_ff [lld_pkg::MAX_SERVERS];
   logic [lld_pkg::REQ_SLOTS-1:0] valid_ff;
   logic                         valid_rd_ff;
   logic [lld_pkg::SRV_W-1:0]    tag_mem [lld_pkg::REQ_SLOTS];
   logic [lld_pkg::SRV_W-1:0]    tag_rd_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lld_pkg::SRV_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [lld_pkg::LOAD_W-1:0]   rsp_load_ff, rsp_load_in;
   logic [lld_pkg::ERR_W-1:0]    rsp_err_ff, rsp_err_in;

   logic                         req_accept;
   logic                         rsp_free;
   logic [lld_pkg::CMP_W-1:0]    fleet_n;

   logic                         load_wr;
   logic [lld_pkg::SRV_W-1:0]    load_wr_idx;
   logic [lld_pkg::LOAD_W-1:0]   load_wr_val;
   logic                         tag_wr;
   logic                         valid_set;
   logic                         valid_clr;

   logic                         tree_start;
   logic                         tree_done;
   lld_pkg::cand_type            tree_cands [lld_pkg::TREE_SIZE];
   lld_pkg::cand_type            winner;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign fleet_n = (lld_pkg::CMP_W'(active_ff) > lld_pkg::CMP_W'(lld_pkg::MAX_SERVERS))
                    ? lld_pkg::CMP_W'(lld_pkg::MAX_SERVERS) : lld_pkg::CMP_W'(active_ff);

   // candidates for the search, servers outside the fleet masked off
   always_comb begin
      for (int i = 0; i < lld_pkg::TREE_SIZE; i++) begin
         tree_cands[i].idx  = lld_pkg::SRV_W'(i);
         tree_cands[i].ok   = 1'b0;
         tree_cands[i].load = '0;
         if (i < lld_pkg::MAX_SERVERS) begin
            tree_cands[i].ok   = lld_pkg::CMP_W'(i) < fleet_n;
            tree_cands[i].load = load_ff[lld_pkg::SRV_W'(i)];
         end
      end
   end

   lld_min_tree u_min_tree (
      .clock  (clock),
      .reset  (reset),
      .start  (tree_start),
      .cands  (tree_cands),
      .done   (tree_done),
      .winner (winner)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_err_in   = rsp_err_ff;
      load_wr      = 1'b0;
      load_wr_idx  = tag_rd_ff;
      load_wr_val  = lld_pkg::sat_sub(load_ff[tag_rd_ff], weight_ff);
      tag_wr       = 1'b0;
      valid_set    = 1'b0;
      valid_clr    = 1'b0;
      tree_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (func_ff == lld_pkg::FUNC_FINISH) begin
               if (rsp_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  if (!valid_rd_ff) begin
                     rsp_idx_in  = '0;
                     rsp_load_in = '0;
                     rsp_err_in  = lld_pkg::ERR_UNKNOWN_TAG;
                  end else begin
                     load_wr     = 1'b1;
                     valid_clr   = 1'b1;
                     rsp_idx_in  = tag_rd_ff;
                     rsp_load_in = load_wr_val;
                     rsp_err_in  = lld_pkg::ERR_OK;
                  end
               end
            end else if (fleet_n == '0) begin
               if (rsp_free) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_load_in  = '0;
                  rsp_err_in   = lld_pkg::ERR_NO_SERVERS;
               end
            end else begin
               tree_start = 1'b1;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (tree_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            load_wr_idx = winner.idx;
            load_wr_val = lld_pkg::sat_add(winner.load, weight_ff);
            if (rsp_free) begin
               state_in     = ST_IDLE;
               load_wr      = 1'b1;
               tag_wr       = 1'b1;
               valid_set    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = winner.idx;
               rsp_load_in  = load_wr_val;
               rsp_err_in   = lld_pkg::ERR_OK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int i = 0; i < lld_pkg::MAX_SERVERS; i++) begin
            load_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            active_ff <= csr_write_data;
         end
         if (load_wr) begin
            load_ff[load_wr_idx] <= load_wr_val;
         end
         if (valid_set) begin
            valid_ff[slot_ff] <= 1'b1;
         end else if (valid_clr) begin
            valid_ff[slot_ff] <= 1'b0;
         end
      end
   end

   // item capture and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= req_func;
         slot_ff   <= lld_pkg::slot_of(req_request_tag);
         weight_ff <= req_work_weight;
      end
      rsp_idx_ff  <= rsp_idx_in;
      rsp_load_ff <= rsp_load_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // request table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (tag_wr) begin
         tag_mem[slot_ff] <= winner.idx;
      end
      if (req_accept) begin
         tag_rd_ff   <= tag_mem[lld_pkg::slot_of(req_request_tag)];
         valid_rd_ff <= valid_ff[lld_pkg::slot_of(req_request_tag)];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_server_index    = lld_pkg::INDEX_W'(rsp_idx_ff);
   assign rsp_server_load_now = rsp_load_ff;
   assign rsp_error_code      = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_LOOK)
      else $error("transfer did not move to table lookup");

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      tree_done |-> state_ff == ST_REDUCE)
      else $error("search finished outside the search state");

   a_finish_frees_tag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK && func_ff == lld_pkg::FUNC_FINISH && rsp_free
      |=> !valid_ff[$past(slot_ff)])
      else $error("finish left the tag valid");

   a_assign_records_tag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE && rsp_free
      |=> valid_ff[$past(slot_ff)] && rsp_valid_ff && rsp_err_ff == lld_pkg::ERR_OK)
      else $error("assign did not record the tag");

   a_error_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff != lld_pkg::ERR_OK |-> rsp_idx_ff == '0 && rsp_load_ff == '0)
      else $error("error result carries a server or load");
`endif

endmodule

/* tb/sv/least_loaded_dispatcher_tb.sv */
// least_loaded_dispatcher_tb: self-checking testbench for the least-loaded dispatcher,
// with a scoreboard class that tracks server loads and the request table
// depends on lld_pkg and least_loaded_dispatcher
module least_loaded_dispatcher_tb;

   class dispatch_scoreboard;
      typedef struct packed {
         logic [lld_pkg::INDEX_W-1:0] idx;
         logic [lld_pkg::LOAD_W-1:0]  load;
         logic [lld_pkg::ERR_W-1:0]   err;
      } grant_type;

      logic [lld_pkg::LOAD_W-1:0] load [lld_pkg::MAX_SERVERS];
      int unsigned                owner [lld_pkg::REQ_SLOTS];
      bit                         live [lld_pkg::REQ_SLOTS];
      bit                         written [lld_pkg::REQ_SLOTS];
      logic [lld_pkg::CSR_W-1:0]  fleet;
      grant_type                  pending_grants [$];
      int unsigned                errors;
      int unsigned                assigns, finishes, no_server, unknown_tag, saturated;

      function new();
         foreach (load[s]) load[s] = '0;
         foreach (live[t]) begin
            live[t] = 1'b0;
            written[t] = 1'b0;
            owner[t] = 0;
         end
         fleet = '0;
         errors = 0;
         assigns = 0;
         finishes = 0;
         no_server = 0;
         unknown_tag = 0;
         saturated = 0;
      endfunction

      function void set_fleet(logic [lld_pkg::CSR_W-1:0] value);
         fleet = value;
      endfunction

      function int pending();
         return pending_grants.size();
      endfunction

      // work out the grant for an accepted request and update loads and table
      function void predict_grant(logic func, logic [lld_pkg::TAG_W-1:0] tag,
                                  logic [lld_pkg::WEIGHT_W-1:0] weight);
         grant_type                due;
         int unsigned              span, slot, pick;
         logic [lld_pkg::LOAD_W:0] sum;
         due = '0;
         slot = tag % lld_pkg::REQ_SLOTS;
         pick = 0;
         if (func == lld_pkg::FUNC_ASSIGN) begin
            assigns++;
            span = (fleet > lld_pkg::MAX_SERVERS) ? lld_pkg::MAX_SERVERS : fleet;
            if (span == 0) begin
               due.err = lld_pkg::ERR_NO_SERVERS;
               no_server++;
            end else begin
               for (int s = 1; s < span; s++) begin
                  if (load[s] < load[pick]) pick = s;
               end
               sum = {1'b0, load[pick]}
                     + {{(lld_pkg::LOAD_W + 1 - lld_pkg::WEIGHT_W){1'b0}}, weight};
               if (sum[lld_pkg::LOAD_W]) saturated++;
               load[pick] = sum[lld_pkg::LOAD_W] ? {lld_pkg::LOAD_W{1'b1}}
                                                 : sum[lld_pkg::LOAD_W-1:0];
               owner[slot] = pick;
               live[slot] = 1'b1;
               written[slot] = 1'b1;
               due.idx = lld_pkg::INDEX_W'(pick);
               due.load = load[pick];
            end
         end else begin
            finishes++;
            if (!live[slot]) begin
               due.err = lld_pkg::ERR_UNKNOWN_TAG;
               unknown_tag++;
            end else begin
               pick = owner[slot] % lld_pkg::MAX_SERVERS;
               load[pick] = (load[pick] > lld_pkg::LOAD_W'(weight))
                            ? load[pick] - lld_pkg::LOAD_W'(weight) : '0;
               live[slot] = 1'b0;
               due.idx = lld_pkg::INDEX_W'(pick);
               due.load = load[pick];
            end
         end
         pending_grants.push_back(due);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
      endtask

      task check_grant(logic [lld_pkg::INDEX_W-1:0] idx, logic [lld_pkg::LOAD_W-1:0] ld,
                       logic [lld_pkg::ERR_W-1:0] err);
         grant_type due;
         if (pending_grants.size() == 0) begin
            report_mismatch($sformatf(
               "result with nothing outstanding: server %0d load %0h code %0d", idx, ld, err));
         end else begin
            due = pending_grants.pop_front();
            if (idx !== due.idx)
               report_mismatch($sformatf("server_index %0d, predicted %0d", idx, due.idx));
            if (ld !== due.load)
               report_mismatch($sformatf("server_load_now %0h, predicted %0h", ld, due.load));
            if (err !== due.err)
               report_mismatch($sformatf("error_code %0d, predicted %0d", err, due.err));
         end
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [lld_pkg::CSR_W-1:0]    csr_write_data;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_func;
   logic [lld_pkg::TAG_W-1:0]    req_request_tag;
   logic [lld_pkg::WEIGHT_W-1:0] req_work_weight;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [lld_pkg::INDEX_W-1:0]  rsp_server_index;
   logic [lld_pkg::LOAD_W-1:0]   rsp_server_load_now;
   logic [lld_pkg::ERR_W-1:0]    rsp_error_code;

   int unsigned                  req_gap_max = 0;
   int unsigned                  rsp_stall_max = 0;
   int unsigned                  rsp_hold_cycles = 0;
   logic [lld_pkg::WEIGHT_W-1:0] tag_weight [lld_pkg::REQ_SLOTS];

   dispatch_scoreboard sb = new();

   least_loaded_dispatcher u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_request_tag     (req_request_tag),
      .req_work_weight     (req_work_weight),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_server_index    (rsp_server_index),
      .rsp_server_load_now (rsp_server_load_now),
      .rsp_error_code      (rsp_error_code)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #100_000_000;
      $display("least_loaded_dispatcher: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.predict_grant(req_func, req_request_tag, req_work_weight);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_grant(rsp_server_index, rsp_server_load_now, rsp_error_code);
   end

   // result side: random stall per transfer, or one long hold when asked
   initial begin : rsp_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_request(input logic func, input logic [lld_pkg::TAG_W-1:0] tag,
                               input logic [lld_pkg::WEIGHT_W-1:0] weight);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_request_tag <= tag;
      req_work_weight <= weight;
      if (func == lld_pkg::FUNC_ASSIGN) tag_weight[tag] = weight;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_fleet(input logic [lld_pkg::CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_fleet(value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait for a clock edge first so the last transfer is noted before the count is read
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // mostly assigns and finishes of live tags, some finishes of freed tags
   task automatic send_random_item();
      int unsigned                  roll, shape;
      logic [lld_pkg::TAG_W-1:0]    tag;
      logic [lld_pkg::WEIGHT_W-1:0] weight;
      int unsigned                  live_tags [$];
      int unsigned                  freed_tags [$];
      for (int t = 0; t < lld_pkg::REQ_SLOTS; t++) begin
         if (sb.live[t]) live_tags.push_back(t);
         else if (sb.written[t]) freed_tags.push_back(t);
      end
      roll = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      if (shape == 0) weight = '0;
      else if (shape == 1) weight = '1;
      else if (shape < 5) weight = lld_pkg::WEIGHT_W'($urandom_range(0, 255));
      else weight = lld_pkg::WEIGHT_W'($urandom);
      if (roll >= 90 && freed_tags.size() != 0) begin
         tag = lld_pkg::TAG_W'(freed_tags[$urandom_range(0, freed_tags.size() - 1)]);
         send_request(lld_pkg::FUNC_FINISH, tag, weight);
      end else if (roll >= 50 && live_tags.size() != 0) begin
         tag = lld_pkg::TAG_W'(live_tags[$urandom_range(0, live_tags.size() - 1)]);
         if (roll < 70) weight = tag_weight[tag];
         send_request(lld_pkg::FUNC_FINISH, tag, weight);
      end else begin
         send_request(lld_pkg::FUNC_ASSIGN, lld_pkg::TAG_W'($urandom_range(0, 255)), weight);
      end
   endtask

   initial begin : stimulus
      logic [lld_pkg::CSR_W-1:0] fleet_plan [8];
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_func = lld_pkg::FUNC_ASSIGN;
      req_request_tag = '0;
      req_work_weight = '0;
      foreach (tag_weight[t]) tag_weight[t] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty fleet from reset, then the table and load corners
      req_gap_max = 11;
      rsp_stall_max = 11;
      send_request(lld_pkg::FUNC_ASSIGN, 8'h5A, 16'd100);
      wait_drain();
      write_fleet(5'd31);
      send_request(lld_pkg::FUNC_ASSIGN, 8'h00, 16'hFFFF);
      send_request(lld_pkg::FUNC_ASSIGN, 8'hFF, 16'h0000);
      send_request(lld_pkg::FUNC_ASSIGN, 8'h01, 16'h0001);
      send_request(lld_pkg::FUNC_FINISH, 8'h00, 16'hFFFF);
      send_request(lld_pkg::FUNC_FINISH, 8'h00, 16'h0005);
      send_request(lld_pkg::FUNC_ASSIGN, 8'h01, 16'h0007);
      send_request(lld_pkg::FUNC_FINISH, 8'h01, 16'hFFFF);
      for (int i = 0; i < 12; i++)
         send_request(lld_pkg::FUNC_ASSIGN, lld_pkg::TAG_W'(8'h40 + i), 16'h4000);
      wait_drain();
      // shrunk fleet: release on a server outside it
      write_fleet(5'd1);
      send_request(lld_pkg::FUNC_FINISH, 8'h4B, 16'h0010);
      wait_drain();
      write_fleet(5'd0);
      send_request(lld_pkg::FUNC_FINISH, 8'h40, 16'h0020);
      send_request(lld_pkg::FUNC_ASSIGN, 8'h41, 16'h0030);
      wait_drain();

      fleet_plan[0] = 5'd16;
      fleet_plan[1] = 5'd1;
      fleet_plan[2] = 5'd2;
      fleet_plan[3] = 5'd31;
      fleet_plan[4] = 5'd0;
      fleet_plan[5] = lld_pkg::CSR_W'($urandom_range(3, 15));
      fleet_plan[6] = lld_pkg::CSR_W'($urandom_range(17, 30));
      fleet_plan[7] = 5'd16;
      for (int p = 0; p < 8; p++) begin
         req_gap_max = (p == 2 || p == 3 || p == 6) ? 0 : 11;
         rsp_stall_max = (p == 2 || p == 5) ? 0 : 11;
         write_fleet(fleet_plan[p]);
         if (p == 3) rsp_hold_cycles = 300;
         for (int k = 0; k < 75; k++) send_random_item();
         wait_drain();
      end
      repeat (10) @(posedge clock);

      $display("covered %0d assigns (%0d with no servers, %0d saturating),",
               sb.assigns, sb.no_server, sb.saturated);
      $display("%0d finishes (%0d unknown), fleet sizes 0, 1, 2, 16, 31 and random, %s",
               sb.finishes, sb.unknown_tag, "with a long output hold and drained pauses");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("least_loaded_dispatcher: match");
      else
         $display("least_loaded_dispatcher: mismatch");
      $finish;
   end

endmodule
